// File: hdl/assert_macros.svh
// assertion macros used by trs_to_affine_matrix
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// File: hdl/trsm_pkg.sv
`timescale 1ns / 1ps
// package for the trs to matrix block: constants, types and the atan table
// no dependencies
package trsm_pkg;
  localparam int CordicStepsDef = 16;
  localparam int TableLen = 24;
  localparam int AngW = 17;
  localparam logic [16:0] AngleFull = 17'd46080;
  localparam logic [16:0] AngleQuarter = 17'd11520;
  localparam logic [33:0] RadPerUnit = 34'd9595049034;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [47:0] OutMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] OutMin = 48'sh8000_0000_0000;
  localparam logic signed [47:0] OneQ16 = 48'sd65536;

  typedef logic signed [33:0] q30_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [23:0] sx, sy, sz;
  } pass_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0: v = 34'sd843314857;
      5'd1: v = 34'sd497837829;
      5'd2: v = 34'sd263043837;
      5'd3: v = 34'sd133525159;
      5'd4: v = 34'sd67021687;
      5'd5: v = 34'sd33543516;
      5'd6: v = 34'sd16775851;
      5'd7: v = 34'sd8388437;
      5'd8: v = 34'sd4194283;
      5'd9: v = 34'sd2097149;
      default: v = 34'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

  // product of two q4.30 rounded back to q4.30
  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return q30_t'(p >>> 30);
  endfunction
endpackage

// File: hdl/trsm_sincos.sv
`timescale 1ns / 1ps
// pipelined sine/cosine: angle reduction, one cordic step per stage, quadrant fix
// depends on trsm_pkg
module trsm_sincos #(
  parameter int CORDIC_STEPS = trsm_pkg::CordicStepsDef
) (
  input  logic clk,
  input  logic en,
  input  logic signed [16:0] ang,
  output trsm_pkg::q30_t cos_o,
  output trsm_pkg::q30_t sin_o
);
  import trsm_pkg::*;
  localparam int N = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;

  logic [16:0] a_r;
  logic [1:0] q_s [0:N];
  logic signed [33:0] z_s [0:N];
  logic signed [33:0] x_s [0:N];
  logic signed [33:0] y_s [0:N];
  logic [16:0] a_mod, r_c;
  logic [1:0] q_c;
  logic [50:0] zp;

  // stage a: fold the angle into one turn, 0 to 46079
  always_comb begin
    if (ang < -$signed({1'b0, AngleFull}))
      a_mod = 17'(ang + $signed({1'b0, AngleFull, 1'b0}));
    else if (ang < 0)
      a_mod = 17'(ang + $signed({1'b0, AngleFull}));
    else if (ang >= $signed({1'b0, AngleFull}))
      a_mod = 17'(ang - $signed({1'b0, AngleFull}));
    else a_mod = ang;
  end

  always_ff @(posedge clk) begin
    if (en) a_r <= a_mod;
  end

  always_comb begin
    if (a_r >= 17'(3 * 11520)) begin q_c = 2'd3; r_c = a_r - 17'(3 * 11520); end
    else if (a_r >= 17'(2 * 11520)) begin q_c = 2'd2; r_c = a_r - 17'(2 * 11520); end
    else if (a_r >= AngleQuarter) begin q_c = 2'd1; r_c = a_r - AngleQuarter; end
    else begin q_c = 2'd0; r_c = a_r; end
    zp = 51'(r_c) * 51'(RadPerUnit) + 51'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_s[0] <= $signed(zp[49:16]);
      x_s[0] <= CordicGain;
      y_s[0] <= '0;
      q_s[0] <= q_c;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - atan_q30(5'(i));
        end else begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + atan_q30(5'(i));
        end
        q_s[i+1] <= q_s[i];
      end
    end
  end

  always_comb begin
    unique case (q_s[N])
      2'd1: begin cos_o = -y_s[N]; sin_o = x_s[N]; end
      2'd2: begin cos_o = -x_s[N]; sin_o = -y_s[N]; end
      2'd3: begin cos_o = y_s[N]; sin_o = -x_s[N]; end
      default: begin cos_o = x_s[N]; sin_o = y_s[N]; end
    endcase
  end
endmodule

// File: hdl/trs_to_affine_matrix.sv
`timescale 1ns / 1ps
// translate-rotate-scale to column-major 4x4 matrix, four column words per transform
// input words pass the angle registers, the cordic steps (capped at 24), stages m1 to m3 and the serialiser
// new transforms keep entering while the single output channel sends columns, until a matrix waits in m3
// the pipeline advances as one, stalling only when the column serialiser is full
// reset: synchronous, active high; clears valid bits, the busy flag and the column counter
// depends on trsm_pkg, trsm_sincos and assert_macros.svh
`include "assert_macros.svh"
module trs_to_affine_matrix #(
  parameter int CORDIC_STEPS = trsm_pkg::CordicStepsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, scale_x, scale_y, scale_z, zero pad
  input  logic [223:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // column_index, row0, row1, row2, row3, zero pad
  output logic [199:0] m_axis_tdata,
  output logic m_axis_tlast
);
  import trsm_pkg::*;
  localparam int N = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;
  localparam int LAT = N + 2; // cordic depth

  // pipeline advance: whole pipe moves unless the serialiser is busy and cannot yet take the matrix in stage m3
  logic adv;
  logic [LAT-1:0] vld;
  pass_t pass_s [0:LAT-1];
  pass_t pin;
  q30_t cx, sx, cy, sy, cz, sz;

  // output holding: 9 rotation*scale values and the position
  logic busy;
  logic [1:0] col;

  assign pin = '{px: s_axis_tdata[31:0], py: s_axis_tdata[63:32], pz: s_axis_tdata[95:64],
                 sx: s_axis_tdata[170:147], sy: s_axis_tdata[194:171],
                 sz: s_axis_tdata[218:195]};

  logic full_ok;
  assign adv = full_ok;
  assign s_axis_tready = adv;

  trsm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_x (.clk, .en(adv),
    .ang(s_axis_tdata[112:96]), .cos_o(cx), .sin_o(sx));
  trsm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_y (.clk, .en(adv),
    .ang(s_axis_tdata[129:113]), .cos_o(cy), .sin_o(sy));
  trsm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_z (.clk, .en(adv),
    .ang(s_axis_tdata[146:130]), .cos_o(cz), .sin_o(sz));

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], s_axis_tvalid};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pass_s[0] <= pin;
      for (int k = 1; k < LAT; k++) pass_s[k] <= pass_s[k-1];
    end
  end

  // stage m1: pair products
  q30_t czcy, szcy, czsy, szsy, szcx, czcx, cysx, szsx, czsx, cycx, nsy, sx1, cx1;
  logic v1;
  pass_t p1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= vld[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      czcy <= mul30(cz, cy); szcy <= mul30(sz, cy);
      czsy <= mul30(cz, sy); szsy <= mul30(sz, sy);
      szcx <= mul30(sz, cx); czcx <= mul30(cz, cx);
      cysx <= mul30(cy, sx); szsx <= mul30(sz, sx);
      czsx <= mul30(cz, sx); cycx <= mul30(cy, cx);
      nsy <= -sy; sx1 <= sx; cx1 <= cx;
      p1 <= pass_s[LAT-1];
    end
  end

  // stage m2: triple products and sums
  q30_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic v2;
  pass_t p2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r00 <= czcy; r01 <= szcy; r02 <= nsy;
      r10 <= mul30(czsy, sx1) - szcx;
      r11 <= mul30(szsy, sx1) + czcx;
      r12 <= cysx;
      r20 <= mul30(czsy, cx1) + szsx;
      r21 <= mul30(szsy, cx1) - czsx;
      r22 <= cycx;
      p2 <= p1;
    end
  end

  // stage m3: scale, round and sign-extend to 48 bits
  function automatic logic [47:0] scl_sat(input q30_t r, input logic signed [23:0] s);
    logic signed [58:0] p;
    logic signed [28:0] t;
    p = r * s + 59'sd536870912;
    t = 29'(p >>> 30);
    return 48'(t);
  endfunction
  logic [47:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  pass_t p3;
  logic v3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m00 <= scl_sat(r00, p2.sx); m01 <= scl_sat(r01, p2.sx); m02 <= scl_sat(r02, p2.sx);
      m10 <= scl_sat(r10, p2.sy); m11 <= scl_sat(r11, p2.sy); m12 <= scl_sat(r12, p2.sy);
      m20 <= scl_sat(r20, p2.sz); m21 <= scl_sat(r21, p2.sz); m22 <= scl_sat(r22, p2.sz);
      p3 <= p2;
    end
  end

  // serialiser: holds one matrix, sends four column words
  logic [47:0] h [0:11];
  logic last_word;
  assign last_word = busy && col == 2'd3 && m_axis_tready;
  assign full_ok = !busy || !v3 || last_word;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col <= 2'd0;
    end else begin
      if (busy && m_axis_tready) col <= col + 2'd1;
      if (adv && v3) busy <= 1'b1;
      else if (last_word) busy <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv && v3) begin
      h[0] <= m00; h[1] <= m01; h[2] <= m02;
      h[3] <= m10; h[4] <= m11; h[5] <= m12;
      h[6] <= m20; h[7] <= m21; h[8] <= m22;
      h[9] <= 48'(p3.px); h[10] <= 48'(p3.py); h[11] <= 48'(p3.pz);
    end
  end

  logic [47:0] o0, o1, o2, o3;
  always_comb begin
    unique case (col)
      2'd0: begin o0 = h[0]; o1 = h[1]; o2 = h[2]; o3 = '0; end
      2'd1: begin o0 = h[3]; o1 = h[4]; o2 = h[5]; o3 = '0; end
      2'd2: begin o0 = h[6]; o1 = h[7]; o2 = h[8]; o3 = '0; end
      default: begin o0 = h[9]; o1 = h[10]; o2 = h[11]; o3 = OneQ16; end
    endcase
  end
  assign m_axis_tvalid = busy;
  assign m_axis_tlast = busy && col == 2'd3;
  assign m_axis_tdata = {6'd0, o3, o2, o1, o0, col};

  `CHK_IMPL(a_last_col3, clk, rst, m_axis_tlast, col == 2'd3)
  `CHK_IMPL(a_idle_col0, clk, rst, !busy, col == 2'd0)
  `CHK_NEXT(a_load_busy, clk, rst, adv && v3, busy && col == 2'd0)
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for trs_to_affine_matrix: transform words in, four column words out
// depends on trsm_pkg and the block rtl; predicts column words in plain sv arithmetic, typed rows apart
module tb_top;
  import trsm_pkg::*;

  localparam int Steps = 16;
  localparam int WatchLimit = 5000;
  localparam int TailCycles = 60;
  localparam int RandItems = 470;

  // one transform as it enters the block
  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [16:0] ax, ay, az;
    logic signed [23:0] sx, sy, sz;
  } trs_t;

  // one column word as it leaves the block
  typedef struct packed {
    logic [1:0]         idx;
    logic signed [47:0] r0, r1, r2, r3;
    logic               last;
  } col_t;

  // directed row: transform plus a flag for rows whose answer is typed in
  typedef struct {
    trs_t t;
    bit   typed;
  } row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [199:0] m_axis_tdata;
  logic         m_axis_tlast;

  col_t  col_queue[$];
  trs_t  sent_queue[$];
  bit    typed_queue[$];
  int    phase;
  int    mismatches;
  int    cols_seen;
  int    items_in;
  int    idle_count;
  bit    done;

  longint atan_tab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  trs_to_affine_matrix #(.CORDIC_STEPS(Steps)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // rounding shift, floor on negatives
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, 30);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > longint'(OutMax)) return longint'(OutMax);
    if (v < longint'(OutMin)) return longint'(OutMin);
    return v;
  endfunction

  // angle reduction, cordic on the remainder, then quadrant rotation
  task automatic angle_sin_cos(input logic signed [16:0] ang, output longint c,
                               output longint s);
    longint a, q, r, z, x, y, dx, dy;
    int n;
    a = longint'(ang) % 46080;
    if (a < 0) a += 46080;
    q = a / 11520;
    r = a % 11520;
    z = rnd_shift(r * 64'sd9595049034, 16);
    x = 652032874;
    y = 0;
    n = (Steps > 24) ? 24 : Steps;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (q)
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
  endtask

  // expected column words of T * Rz * Ry * Rx * S
  task automatic predict_matrix(input trs_t t);
    longint cx, sx, cy, sy, cz, sz;
    longint rot[3][3];
    longint scl[3];
    longint pos[3];
    col_t w;
    angle_sin_cos(t.ax, cx, sx);
    angle_sin_cos(t.ay, cy, sy);
    angle_sin_cos(t.az, cz, sz);
    scl[0] = t.sx; scl[1] = t.sy; scl[2] = t.sz;
    pos[0] = t.px; pos[1] = t.py; pos[2] = t.pz;
    rot[0][0] = qmul(cz, cy);
    rot[0][1] = qmul(sz, cy);
    rot[0][2] = -sy;
    rot[1][0] = qmul(qmul(cz, sy), sx) - qmul(sz, cx);
    rot[1][1] = qmul(qmul(sz, sy), sx) + qmul(cz, cx);
    rot[1][2] = qmul(cy, sx);
    rot[2][0] = qmul(qmul(cz, sy), cx) + qmul(sz, sx);
    rot[2][1] = qmul(qmul(sz, sy), cx) - qmul(cz, sx);
    rot[2][2] = qmul(cy, cx);
    for (int c = 0; c < 3; c++) begin
      w.idx = 2'(c);
      w.r0 = 48'(clamp48(rnd_shift(rot[c][0] * scl[c], 30)));
      w.r1 = 48'(clamp48(rnd_shift(rot[c][1] * scl[c], 30)));
      w.r2 = 48'(clamp48(rnd_shift(rot[c][2] * scl[c], 30)));
      w.r3 = '0;
      w.last = 1'b0;
      col_queue.insert(col_queue.size(), w);
    end
    w.idx = 2'd3;
    w.r0 = 48'(pos[0]); w.r1 = 48'(pos[1]); w.r2 = 48'(pos[2]);
    w.r3 = OneQ16;
    w.last = 1'b1;
    col_queue.insert(col_queue.size(), w);
  endtask

  // zero scale: rotation columns vanish, column 3 is the position
  task automatic typed_matrix(input trs_t t);
    col_t w;
    for (int c = 0; c < 3; c++) begin
      w = '{idx: 2'(c), r0: '0, r1: '0, r2: '0, r3: '0, last: 1'b0};
      col_queue.insert(col_queue.size(), w);
    end
    w = '{idx: 2'd3, r0: 48'(t.px), r1: 48'(t.py), r2: 48'(t.pz), r3: OneQ16, last: 1'b1};
    col_queue.insert(col_queue.size(), w);
  endtask

  function automatic logic [223:0] pack_trs(trs_t t);
    return {5'd0, t.sz, t.sy, t.sx, t.az, t.ay, t.ax, t.pz, t.py, t.px};
  endfunction

  function automatic trs_t rand_trs();
    trs_t t;
    t.px = $urandom; t.py = $urandom; t.pz = $urandom;
    t.ax = 17'($urandom_range(92160) - 46080);
    t.ay = 17'($urandom_range(92160) - 46080);
    t.az = 17'($urandom_range(92160) - 46080);
    t.sx = 24'($urandom); t.sy = 24'($urandom); t.sz = 24'($urandom);
    return t;
  endfunction

  // sender idles in phases 1 and 3
  function automatic bit sender_gap();
    if (phase == 1) return $urandom_range(99) < 75;
    if (phase == 3) return $urandom_range(99) < 22;
    return 1'b0;
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(input trs_t t, input bit typed);
    while (sender_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_trs(t);
    sent_queue.insert(sent_queue.size(), t);
    typed_queue.insert(typed_queue.size(), typed);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // accept side: predict on input handshakes, check on output handshakes
  always @(posedge clk) begin
    col_t got, want;
    trs_t t;
    bit typed;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        t = sent_queue.pop_front();
        typed = typed_queue.pop_front();
        items_in++;
        if (typed) typed_matrix(t);
        else predict_matrix(t);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        cols_seen++;
        got.idx = m_axis_tdata[1:0];
        got.r0 = m_axis_tdata[49:2];
        got.r1 = m_axis_tdata[97:50];
        got.r2 = m_axis_tdata[145:98];
        got.r3 = m_axis_tdata[193:146];
        got.last = m_axis_tlast;
        if (col_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected column word idx %0d", got.idx);
        end else begin
          want = col_queue.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("column mismatch exp: idx %0d %0d %0d %0d %0d last %0b",
                       want.idx, want.r0, want.r1, want.r2, want.r3, want.last);
              $display("column mismatch got: idx %0d %0d %0d %0d %0d last %0b",
                       got.idx, got.r0, got.r1, got.r2, got.r3, got.last);
            end
          end
        end
      end
      // receiver stalls in phases 2 and 3
      case (phase)
        2: m_axis_tready <= $urandom_range(99) >= 75;
        3: m_axis_tready <= $urandom_range(99) >= 22;
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || done || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_count <= 0;
    else if (idle_count >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end else
      idle_count <= idle_count + 1;
  end

  row_t dir_rows[$];

  initial begin
    trs_t t;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    phase = 0;
    mismatches = 0;
    cols_seen = 0;
    items_in = 0;
    idle_count = 0;
    done = 1'b0;

    // directed stimulus: zeros, extremes, quadrant edges, wrapped angles
    dir_rows.insert(dir_rows.size(), '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0}, 1'b1});
    dir_rows.insert(dir_rows.size(), '{'{32'h80000000, 32'h80000000, 32'h80000000,
                                        46080, -46080, 11520, 0, 0, 0}, 1'b1});
    dir_rows.insert(dir_rows.size(),
                    '{'{65536, -65536, 1, 0, 0, 0, 65536, 65536, 65536}, 1'b0});
    dir_rows.insert(dir_rows.size(),
                    '{'{0, 0, 0, 11520, 23040, 34560, 65536, 65536, 65536}, 1'b0});
    dir_rows.insert(dir_rows.size(),
                    '{'{0, 0, 0, -11520, -23040, -34560, 65536, 65536, 65536}, 1'b0});
    dir_rows.insert(dir_rows.size(),
                    '{'{0, 0, 0, 46080, -46080, 46079, 65536, 65536, 65536}, 1'b0});
    dir_rows.insert(dir_rows.size(),
                    '{'{0, 0, 0, -46079, 1, -1, 65536, 65536, 65536}, 1'b0});
    dir_rows.insert(dir_rows.size(), '{'{0, 0, 0, 11519, 11521, 5760,
                                        24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 1'b0});
    dir_rows.insert(dir_rows.size(), '{'{0, 0, 0, 4000, -9000, 30000,
                                        24'h800000, 24'h800000, 24'h800000}, 1'b0});
    dir_rows.insert(dir_rows.size(), '{'{-1, 1, -1, 17000, 23041, -40000,
                                        -65536, 24'h7FFFFF, 24'h800000}, 1'b0});
    dir_rows.insert(dir_rows.size(), '{'{32'h7FFFFFFF, 32'h80000000, 0, 46080, 46080, 46080,
                                        24'h800000, 24'h7FFFFF, -1}, 1'b0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].t, dir_rows[i].typed);

    // random part spread over the four phases
    for (int p = 0; p < 4; p++) begin
      phase = p;
      for (int k = 0; k < RandItems / 4 + 1; k++) begin
        if (k == 60 && p == 1) begin
          // hold off the sender until the block has drained
          s_axis_tvalid <= 1'b0;
          while (col_queue.size() != 0) @(posedge clk);
        end
        t = rand_trs();
        send_word(t, 1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;
    phase = 0;

    while (col_queue.size() != 0) @(posedge clk);
    done = 1'b1;
    repeat (TailCycles) @(posedge clk);

    $display("ran %0d transforms through all idling phases, %0d column words checked",
             items_in, cols_seen);
    $display("angles covered both signs, quadrant edges and full-turn wraps");
    if (mismatches == 0 && col_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
